/* rtl/core/ssh_pkg.sv */
package ssh_pkg;

    // Start values and mixing constants of the three hashes.
    localparam logic [31:0] DJB_START = 32'd5381;
    localparam int          DJB_SHIFT = 5;
    localparam logic [31:0] CRC_START = 32'hFFFF_FFFF;
    localparam logic [31:0] CRC_POLY  = 32'hEDB8_8320;
    localparam logic [31:0] MIX_MULT  = 32'h5BD1_E995;
    localparam logic [31:0] MIX_START = 32'd0;
    localparam int          MIX_ROTL  = 13;

    typedef enum logic [1:0] {
        HASH_DJB2  = 2'd0,
        HASH_CRC32 = 2'd1,
        HASH_MIX   = 2'd2
    } hash_mode_t;

    // The select register is taken modulo three, so the unused code falls back to djb2.
    function automatic hash_mode_t select_to_mode(input logic [1:0] sel);
        hash_mode_t mode;
        begin
            unique case (sel)
                HASH_CRC32: mode = HASH_CRC32;
                HASH_MIX:   mode = HASH_MIX;
                default:    mode = HASH_DJB2;
            endcase
            return mode;
        end
    endfunction

    function automatic logic [31:0] start_value(input hash_mode_t mode);
        logic [31:0] value;
        begin
            unique case (mode)
                HASH_CRC32: value = CRC_START;
                HASH_MIX:   value = MIX_START;
                default:    value = DJB_START;
            endcase
            return value;
        end
    endfunction

endpackage

/* rtl/core/selectable_string_hash.sv */
// A result is registered from the input register once it holds the byte marked last.
// Throughput: one byte per cycle, unless a finished string waits on an untaken result;
// the hash update loop, which holds the 32-bit constant multiplier of the mix hash, sets that rate.
// Reset (aresetn low, synchronous): both channels empty, no string in progress,
// hash select back to djb2.
module selectable_string_hash
    import ssh_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    // Configuration: hash select, 0 djb2, 1 crc32, 2 multiply-rotate mix.
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_wr_data,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] char_byte
    input  logic        s_tuser,    // [0] byte_present
    input  logic        s_tlast,    // last_byte

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata     // [31:0] hash_value
);

    // Configuration register. The user writes it only while the block is idle; the block
    // does not enforce it. Sampled when the first byte of a string reaches the hash stage.
    logic [1:0] hash_select_reg;

    // Input register: one transfer waits here for the hash stage.
    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic       in_present_reg;
    logic       in_last_reg;

    // Running state of the string in progress.
    logic        active_reg, active_next;
    hash_mode_t  mode_reg, mode_next;
    logic [31:0] hash_reg, hash_next;

    // Result register.
    logic        out_valid_reg, out_valid_next;
    logic [31:0] out_hash_reg, out_hash_next;

    logic        advance;
    logic        process;
    hash_mode_t  cur_mode;
    logic [31:0] base_hash;
    logic [31:0] absorbed;
    logic [31:0] hash_upd;
    logic [31:0] final_hash;

    // The held item moves on unless it would produce a result while the previous
    // result has not yet been taken. Items that produce no result always move on.
    assign advance  = in_valid_reg && !(in_last_reg && out_valid_reg && !m_tready);
    assign s_tready = !in_valid_reg || advance;

    // An item with neither a byte nor the last mark does nothing at all; in
    // particular it does not open a string.
    assign process = advance && (in_present_reg || in_last_reg);

    // At the start of a string the mode is taken from the select register and the
    // hash begins from that mode's start value; otherwise the latched state is used.
    assign cur_mode  = active_reg ? mode_reg : select_to_mode(hash_select_reg);
    assign base_hash = active_reg ? hash_reg : start_value(cur_mode);

    ssh_absorb u_absorb (
        .mode      (cur_mode),
        .hash_in   (base_hash),
        .char_byte (in_byte_reg),
        .hash_out  (absorbed)
    );

    assign hash_upd   = in_present_reg ? absorbed : base_hash;
    // The CRC is inverted on the way out.
    assign final_hash = (cur_mode == HASH_CRC32) ? ~hash_upd : hash_upd;

    always_comb begin
        in_valid_next  = in_valid_reg;
        active_next    = active_reg;
        mode_next      = mode_reg;
        hash_next      = hash_reg;
        out_valid_next = out_valid_reg;
        out_hash_next  = out_hash_reg;

        if (s_tready) begin
            in_valid_next = s_tvalid;
        end

        if (process) begin
            mode_next   = cur_mode;
            hash_next   = hash_upd;
            active_next = !in_last_reg;
        end

        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end
        if (advance && in_last_reg) begin
            out_valid_next = 1'b1;
            out_hash_next  = final_hash;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hash_select_reg <= 2'(HASH_DJB2);
            in_valid_reg    <= 1'b0;
            active_reg      <= 1'b0;
            mode_reg        <= HASH_DJB2;
            hash_reg        <= DJB_START;
            out_valid_reg   <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                hash_select_reg <= cfg_wr_data;
            end
            in_valid_reg  <= in_valid_next;
            active_reg    <= active_next;
            mode_reg      <= mode_next;
            hash_reg      <= hash_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg    <= s_tdata;
            in_present_reg <= s_tuser;
            in_last_reg    <= s_tlast;
        end
        out_hash_reg <= out_hash_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_hash_reg;

    // A new result only ever follows the hash stage finishing a string.
    a_result_from_last: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(in_valid_reg && in_last_reg))
        else $error("result raised without a finished string");

    // A finished string must not overwrite a result that is still waiting.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && in_last_reg && out_valid_reg && !m_tready) |-> !s_tready)
        else $error("input accepted while a finished string is blocked");

    // Emitting a hash closes the string, so the next one reloads its start value.
    a_string_closed: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_last_reg) |=> !active_reg)
        else $error("string still open after its hash was emitted");

endmodule

/* rtl/core/ssh_absorb.sv */
module ssh_absorb
    import ssh_pkg::*;
(
    input  hash_mode_t  mode,
    input  logic [31:0] hash_in,
    input  logic [7:0]  char_byte,
    output logic [31:0] hash_out
);

    logic [31:0] byte_ext;
    logic [31:0] djb_hash;
    logic [31:0] crc_hash;
    logic [31:0] mix_in;
    logic [31:0] mix_prod;
    logic [31:0] mix_hash;

    // The byte is read as a signed char.
    assign byte_ext = {{24{char_byte[7]}}, char_byte};

    assign djb_hash = (hash_in << DJB_SHIFT) + hash_in + byte_ext;

    // Reflected CRC-32 polynomial on the sign-extended byte: eight shift-and-reduce steps.
    always_comb begin
        logic [31:0] crc;
        crc = hash_in ^ byte_ext;
        for (int i = 0; i < 8; i++) begin
            crc = (crc >> 1) ^ (crc[0] ? CRC_POLY : 32'd0);
        end
        crc_hash = crc;
    end

    assign mix_in   = hash_in ^ byte_ext;
    assign mix_prod = mix_in * MIX_MULT;
    assign mix_hash = {mix_prod[31-MIX_ROTL:0], mix_prod[31:32-MIX_ROTL]};

    always_comb begin
        unique case (mode)
            HASH_CRC32: hash_out = crc_hash;
            HASH_MIX:   hash_out = mix_hash;
            default:    hash_out = djb_hash;
        endcase
    end

endmodule
